[rtl/hifr_pkg.sv]
// hifr_pkg: shared widths, constants, word types and the arctangent table
`default_nettype none

package hifr_pkg;

  // field widths of the input and result words
  localparam int DATA_BITS        = 16;
  localparam int ANGLE_BITS       = 16;
  localparam int TICK_BITS        = 16;

  // default number of cordic micro-rotations
  localparam int CORDIC_STEPS_DEF = 16;

  // extra fraction bits carried through the rotation
  localparam int GUARD_BITS       = 12;

  // cordic angle register is a 32-bit binary angle
  localparam int ZW               = 32;
  localparam int ATAN_IDX_W       = 5;

  // round(2^32 / (2*pi)), turns the q4.28 radian product into binary angle
  localparam int INV_BITS         = 30;
  localparam logic [INV_BITS-1:0] INV_TWO_PI_Q32 = 30'd683565276;

  // fraction bits of (q4.28 radians) * (q32 turns per radian)
  localparam int PROD_FRAC        = 60;

  // cordic gain compensation 0.6072529350 in q30
  localparam int GAIN_BITS        = 30;
  localparam logic [GAIN_BITS-1:0] CORDIC_GAIN_Q30 = 30'd652032874;

  // input word: world-frame command for one tick
  typedef struct packed {
    logic signed [DATA_BITS-1:0] vel_x;
    logic signed [DATA_BITS-1:0] vel_y;
    logic signed [DATA_BITS-1:0] yaw_rate;
    logic        [TICK_BITS-1:0] tick_period;
  } hifr_in_t;

  // result word: body-frame velocity and updated heading
  typedef struct packed {
    logic signed [DATA_BITS-1:0]  body_vel_x;
    logic signed [DATA_BITS-1:0]  body_vel_y;
    logic signed [DATA_BITS-1:0]  yaw_rate_out;
    logic        [ANGLE_BITS-1:0] heading_out;
  } hifr_out_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [ZW-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      5'd24:   v = 32'h0000_0029;
      5'd25:   v = 32'h0000_0014;
      5'd26:   v = 32'h0000_000A;
      5'd27:   v = 32'h0000_0005;
      5'd28:   v = 32'h0000_0003;
      5'd29:   v = 32'h0000_0001;
      5'd30:   v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/heading_integrate_frame_rotate.sv]
// heading_integrate_frame_rotate: heading integrator and world-to-body cordic rotation
// each word runs through the bit-serial heading multiplier, the heading update, the angle
//   fold, the one-step-per-cycle cordic unit, the bit-serial gain multiplier and the output
//   step; a new word is taken only after the result of the last one has been loaded
// reset: heading clears to zero (facing world x), the block goes idle, no result pending
`default_nettype none

module heading_integrate_frame_rotate
  import hifr_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire hifr_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output hifr_out_t      out_data_o
);

  // widths
  localparam int MAG_W    = DATA_BITS;              // |yaw_rate|
  localparam int AW       = MAG_W + TICK_BITS;      // |yaw_rate| * period
  localparam int PW       = INV_BITS + AW;          // full increment product
  localparam int PX       = (PW > PROD_FRAC) ? PW : PROD_FRAC;
  localparam int SH       = PROD_FRAC - ANGLE_BITS;
  localparam int CW       = DATA_BITS + GUARD_BITS + 3;
  localparam int RW       = CW - GUARD_BITS + 1;
  localparam int CNT_M0   = (AW > CORDIC_STEPS) ? AW : CORDIC_STEPS;
  localparam int CNT_MAX  = (CNT_M0 > GAIN_BITS) ? CNT_M0 : GAIN_BITS;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);

  localparam logic [ZW-1:0] QUARTER_POS = 32'h4000_0000;
  localparam logic [ZW-1:0] QUARTER_NEG = 32'hC000_0000;
  localparam logic [ZW-1:0] HALF_TURN   = 32'h8000_0000;
  localparam logic [RW-1:0] SAT_HI      = RW'({(DATA_BITS-1){1'b1}});

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_HEAD  = 8'b0000_0010,
    ST_ANGLE = 8'b0000_0100,
    ST_PRE   = 8'b0000_1000,
    ST_ROT   = 8'b0001_0000,
    ST_ABS   = 8'b0010_0000,
    ST_GAIN  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  // round half away from zero on the magnitude, restore sign, saturate
  function automatic logic [DATA_BITS-1:0] round_sat(input logic [CW-1:0] acc,
                                                     input logic neg);
    logic [RW-1:0]        r;
    logic [DATA_BITS-1:0] res;
    r = RW'(acc[CW-1:GUARD_BITS]) + RW'(acc[GUARD_BITS-1]);
    if (neg) begin
      if (r > SAT_HI + RW'(1)) res = {1'b1, {(DATA_BITS-1){1'b0}}};
      else res = DATA_BITS'(RW'(0) - r);
    end else begin
      if (r > SAT_HI) res = {1'b0, {(DATA_BITS-1){1'b1}}};
      else res = r[DATA_BITS-1:0];
    end
    return res;
  endfunction

  // control registers
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [ANGLE_BITS-1:0]   heading_q, heading_d;
  logic                    out_valid_q, out_valid_d;

  // captured input word
  logic signed [DATA_BITS-1:0] vx_q, vx_d;
  logic signed [DATA_BITS-1:0] vy_q, vy_d;
  logic signed [DATA_BITS-1:0] wz_q, wz_d;
  logic                        neg_q, neg_d;

  // bit-serial heading increment multipliers
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic [TICK_BITS-1:0]  per_sr_q, per_sr_d;
  logic [MAG_W-1:0]      acc1_q, acc1_d;
  logic                  a_bit_q, a_bit_d;
  logic [INV_BITS-1:0]   acc2_q, acc2_d;
  logic [AW-1:0]         lo_q, lo_d;

  // cordic unit
  logic signed [CW-1:0]  x_q, x_d;
  logic signed [CW-1:0]  y_q, y_d;
  logic [ZW-1:0]         z_q, z_d;

  // bit-serial gain multipliers
  logic [CW-1:0]         magx_q, magx_d;
  logic [CW-1:0]         magy_q, magy_d;
  logic                  negx_q, negx_d;
  logic                  negy_q, negy_d;
  logic [CW-1:0]         accx_q, accx_d;
  logic [CW-1:0]         accy_q, accy_d;
  logic [GAIN_BITS-1:0]  g_sr_q, g_sr_d;

  hifr_out_t             out_q, out_d;

  // datapath nets
  logic [MAG_W:0]          sum1;
  logic [INV_BITS:0]       sum2;
  logic [PX-1:0]           p_ext;
  logic [ANGLE_BITS-1:0]   head_inc;
  logic [ANGLE_BITS-1:0]   heading_upd;
  logic [ZW-1:0]           head_ang;
  logic [ZW-1:0]           z0;
  logic                    flip;
  logic signed [CW-1:0]    x0;
  logic signed [CW-1:0]    y0;
  logic signed [CW-1:0]    dx;
  logic signed [CW-1:0]    dy;
  logic [ZW-1:0]           atan_v;
  logic [CW:0]             sumx;
  logic [CW:0]             sumy;
  logic                    out_load;

  // stage 1: |yaw_rate| * period, one product bit out per cycle
  assign sum1 = {1'b0, acc1_q} + (per_sr_q[0] ? {1'b0, mag_q} : '0);

  // stage 2: product bit stream times 1/(2*pi)
  assign sum2 = {1'b0, acc2_q} + (a_bit_q ? {1'b0, INV_TWO_PI_Q32} : '0);

  // increment: the top 16 fraction bits as a binary angle, rounded by the next bit down
  assign p_ext       = PX'({acc2_q, lo_q});
  assign head_inc    = p_ext[PROD_FRAC-1:SH] + ANGLE_BITS'(p_ext[SH-1]);
  assign heading_upd = neg_q ? (heading_q - head_inc) : (heading_q + head_inc);

  // rotation angle is minus the heading, folded into +-90 degrees
  assign head_ang = ZW'(heading_q) << (ZW - ANGLE_BITS);
  assign z0       = ZW'(0) - head_ang;
  assign flip     = (!z0[ZW-1] && (z0 > QUARTER_POS)) || (z0[ZW-1] && (z0 < QUARTER_NEG));
  assign x0       = CW'(vx_q) <<< GUARD_BITS;
  assign y0       = CW'(vy_q) <<< GUARD_BITS;

  // one micro-rotation per cycle
  assign dx     = y_q >>> cnt_q[ATAN_IDX_W-1:0];
  assign dy     = x_q >>> cnt_q[ATAN_IDX_W-1:0];
  assign atan_v = atan_turns(cnt_q[ATAN_IDX_W-1:0]);

  // gain compensation, one constant bit per cycle
  assign sumx = {1'b0, accx_q} + (g_sr_q[0] ? {1'b0, magx_q} : '0);
  assign sumy = {1'b0, accy_q} + (g_sr_q[0] ? {1'b0, magy_q} : '0);

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // sequencer and next-state values
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    heading_d   = heading_q;
    out_valid_d = out_valid_q && out_stall_i;
    vx_d        = vx_q;
    vy_d        = vy_q;
    wz_d        = wz_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    per_sr_d    = per_sr_q;
    acc1_d      = acc1_q;
    a_bit_d     = a_bit_q;
    acc2_d      = acc2_q;
    lo_d        = lo_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    magx_d      = magx_q;
    magy_d      = magy_q;
    negx_d      = negx_q;
    negy_d      = negy_q;
    accx_d      = accx_q;
    accy_d      = accy_q;
    g_sr_d      = g_sr_q;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          vx_d     = in_data_i.vel_x;
          vy_d     = in_data_i.vel_y;
          wz_d     = in_data_i.yaw_rate;
          neg_d    = in_data_i.yaw_rate[DATA_BITS-1];
          mag_d    = in_data_i.yaw_rate[DATA_BITS-1] ?
                     MAG_W'(MAG_W'(0) - in_data_i.yaw_rate) : MAG_W'(in_data_i.yaw_rate);
          per_sr_d = in_data_i.tick_period;
          acc1_d   = '0;
          a_bit_d  = 1'b0;
          acc2_d   = '0;
          lo_d     = '0;
          cnt_d    = '0;
          state_d  = ST_HEAD;
        end
      end
      ST_HEAD: begin
        acc1_d   = sum1[MAG_W:1];
        a_bit_d  = sum1[0];
        per_sr_d = per_sr_q >> 1;
        // second stage takes the product bit that the first stage registered in a_bit
        if (cnt_q != '0) begin
          acc2_d = sum2[INV_BITS:1];
          lo_d   = {sum2[0], lo_q[AW-1:1]};
        end
        if (cnt_q == CNT_W'(AW)) begin
          cnt_d   = '0;
          state_d = ST_ANGLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_ANGLE: begin
        heading_d = heading_upd;
        state_d   = ST_PRE;
      end
      ST_PRE: begin
        x_d     = flip ? -x0 : x0;
        y_d     = flip ? -y0 : y0;
        z_d     = flip ? (z0 ^ HALF_TURN) : z0;
        cnt_d   = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        if (!z_q[ZW-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_v;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_v;
        end
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_ABS;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_ABS: begin
        negx_d  = x_q[CW-1];
        negy_d  = y_q[CW-1];
        magx_d  = x_q[CW-1] ? $unsigned(-x_q) : $unsigned(x_q);
        magy_d  = y_q[CW-1] ? $unsigned(-y_q) : $unsigned(y_q);
        accx_d  = '0;
        accy_d  = '0;
        g_sr_d  = CORDIC_GAIN_Q30;
        cnt_d   = '0;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        accx_d = sumx[CW:1];
        accy_d = sumy[CW:1];
        g_sr_d = g_sr_q >> 1;
        if (cnt_q == CNT_W'(GAIN_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_d.body_vel_x   = round_sat(accx_q, negx_q);
          out_d.body_vel_y   = round_sat(accy_q, negy_q);
          out_d.yaw_rate_out = wz_q;
          out_d.heading_out  = heading_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      heading_q   <= heading_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    wz_q     <= wz_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    per_sr_q <= per_sr_d;
    acc1_q   <= acc1_d;
    a_bit_q  <= a_bit_d;
    acc2_q   <= acc2_d;
    lo_q     <= lo_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    magx_q   <= magx_d;
    magy_q   <= magy_d;
    negx_q   <= negx_d;
    negy_q   <= negy_d;
    accx_q   <= accx_d;
    accy_q   <= accy_d;
    g_sr_q   <= g_sr_d;
    out_q    <= out_d;
  end

  // ports
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted word starts the heading multiply from a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_HEAD) && (cnt_q == '0))
    else $error("accepted word did not start the heading multiply");

  // the first serial multiplier stage has drained when the heading phase ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEAD) && (cnt_q == CNT_W'(AW)) |-> (per_sr_q == '0) && (acc1_q == '0))
    else $error("heading multiplier not drained at end of phase");

  // heading only moves on the update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heading_q != $past(heading_q)) |-> ($past(state_q) == ST_ANGLE))
    else $error("heading changed outside its update cycle");

  // a new result word only comes from the output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result word raised outside the output step");

  // rotation count stays inside the micro-rotation range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT) |-> (cnt_q < CNT_W'(CORDIC_STEPS)))
    else $error("cordic step count out of range");

endmodule

`default_nettype wire

[tb/tb_heading_integrate_frame_rotate.sv]
// tb_heading_integrate_frame_rotate: heading integration and body-frame rotation checks

module tb_heading_integrate_frame_rotate
  import hifr_pkg::*;
();

  // run limits, in clock cycles, and the number of random command words
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_WORDS = 680;

  // expected result words and a private copy of the heading integrator
  class frame_rotate_board;
    hifr_out_t             expected_words[$];
    logic [ANGLE_BITS-1:0] heading;
    longint                atan_q32[16];
    int                    mismatch_cnt;

    function new();
      heading      = '0;
      mismatch_cnt = 0;
      atan_q32 = '{64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
                   64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
                   64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
                   64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D};
    endfunction

    // gain compensation, round half away from zero, saturate
    function logic signed [DATA_BITS-1:0] gain_round_sat(input longint v);
      longint unsigned mag;
      longint unsigned r;
      longint unsigned sat_hi;
      longint          res;
      sat_hi = (64'd1 << (DATA_BITS - 1)) - 1;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      mag = mag * 64'(CORDIC_GAIN_Q30);
      r = (mag + (64'd1 << (GAIN_BITS + GUARD_BITS - 1))) >> (GAIN_BITS + GUARD_BITS);
      if (v < 0) res = (r > sat_hi + 1) ? -longint'(sat_hi) - 1 : -longint'(r);
      else       res = (r > sat_hi) ? longint'(sat_hi) : longint'(r);
      return DATA_BITS'(res);
    endfunction

    // advance the heading, then rotate the command by minus the heading
    function hifr_out_t rotate_to_body(input hifr_in_t cmd);
      longint unsigned mag;
      longint unsigned inc;
      logic [ZW-1:0]   a32;
      longint          x, y, z, t, dx, dy;
      hifr_out_t       res;
      mag = longint'(cmd.yaw_rate);
      if (cmd.yaw_rate < 0) mag = -mag;
      mag = mag * 64'(cmd.tick_period) * 64'(INV_TWO_PI_Q32);
      inc = (mag + (64'd1 << (PROD_FRAC - ANGLE_BITS - 1))) >> (PROD_FRAC - ANGLE_BITS);
      if (cmd.yaw_rate < 0) inc = -inc;
      heading = heading + inc[ANGLE_BITS-1:0];

      // angle is minus the heading as a 32-bit binary angle
      a32 = ZW'(0) - (ZW'(heading) << (ZW - ANGLE_BITS));
      z = longint'(signed'(a32));
      x = longint'(cmd.vel_x) * (longint'(1) << GUARD_BITS);
      y = longint'(cmd.vel_y) * (longint'(1) << GUARD_BITS);

      // fold angles beyond a quarter turn by negating the vector
      if (z > 64'sh4000_0000) begin
        x = -x; y = -y; z = z - 64'sh8000_0000;
      end else if (z < -64'sh4000_0000) begin
        x = -x; y = -y; z = z + 64'sh8000_0000;
      end

      // micro-rotations, shifts floor toward minus infinity
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          t = x - dx; y = y + dy; x = t; z = z - atan_q32[i];
        end else begin
          t = x + dx; y = y - dy; x = t; z = z + atan_q32[i];
        end
      end

      res.body_vel_x   = gain_round_sat(x);
      res.body_vel_y   = gain_round_sat(y);
      res.yaw_rate_out = cmd.yaw_rate;
      res.heading_out  = heading;
      return res;
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      mismatch_cnt++;
    endtask

    function void note_command(input hifr_in_t cmd);
      expected_words.insert(expected_words.size(), rotate_to_body(cmd));
    endfunction

    // compare one result word against the oldest expected word
    task check_word(input hifr_out_t got);
      hifr_out_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("result word %h with no command pending", got));
      end else begin
        want = expected_words.pop_front();
        if (got.body_vel_x !== want.body_vel_x)
          report($sformatf("body_vel_x got %0d want %0d", got.body_vel_x, want.body_vel_x));
        if (got.body_vel_y !== want.body_vel_y)
          report($sformatf("body_vel_y got %0d want %0d", got.body_vel_y, want.body_vel_y));
        if (got.yaw_rate_out !== want.yaw_rate_out)
          report($sformatf("yaw_rate_out got %0d want %0d",
                           got.yaw_rate_out, want.yaw_rate_out));
        if (got.heading_out !== want.heading_out)
          report($sformatf("heading_out got %0d want %0d", got.heading_out, want.heading_out));
      end
    endtask

    function int pending_count();
      return expected_words.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  hifr_in_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  hifr_out_t out_data_o;

  frame_rotate_board board;
  bit                no_idle       = 1'b0;
  bit                hold_off_req  = 1'b0;
  int                idle_cycles   = 0;

  heading_integrate_frame_rotate DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // handshake monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_command(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_word(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n == 0) begin
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end else begin
        // stall over a waiting word, then release the stall
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (n - 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

  // offer one command word after a random gap, hold it until taken
  task automatic send_command(input logic [DATA_BITS-1:0] vx, input logic [DATA_BITS-1:0] vy,
                              input logic [DATA_BITS-1:0] wz,
                              input logic [TICK_BITS-1:0] per);
    hifr_in_t cmd;
    int       gap;
    cmd.vel_x       = vx;
    cmd.vel_y       = vy;
    cmd.yaw_rate    = wz;
    cmd.tick_period = per;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // velocity or yaw rate: extremes, small values or anything
  function automatic logic [DATA_BITS-1:0] pick_signed();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'hffff;
      3, 4:    return 16'($urandom_range(0, 512) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // tick period: short ticks as often as anything, sometimes zero or full
  function automatic logic [TICK_BITS-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:          return 16'h0000;
      1:          return 16'hffff;
      2, 3, 4, 5: return 16'($urandom_range(0, 16'h0400));
      default:    return 16'($urandom);
    endcase
  endfunction

  initial begin
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, extremes, quarter-turn steps, tiny and huge increments
    send_command(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    send_command(16'h8000, 16'h8000, 16'h0000, 16'h0000);
    send_command(16'h4000, 16'h1000, 16'd6434, 16'hffff);
    send_command(16'h4000, 16'h1000, 16'd6434, 16'hffff);
    send_command(16'hc000, 16'h1000, 16'd6434, 16'hffff);
    send_command(16'h4000, 16'hf000, 16'd6434, 16'hffff);
    send_command(16'h7fff, 16'h7fff, 16'd3217, 16'hffff);
    send_command(16'h8000, 16'h8000, 16'd3217, 16'hffff);
    send_command(16'h8000, 16'h7fff, -16'sd6434, 16'hffff);
    send_command(16'h7fff, 16'h8000, -16'sd3217, 16'hffff);
    send_command(16'h1234, 16'hedcb, 16'h7fff, 16'hffff);
    send_command(16'h1234, 16'hedcb, 16'h8000, 16'hffff);
    send_command(16'h0800, 16'h0800, 16'h8000, 16'h0000);
    send_command(16'h0800, 16'hf800, 16'h0000, 16'hffff);
    send_command(16'h0001, 16'hffff, 16'h0001, 16'h0001);
    send_command(16'hffff, 16'h0001, 16'hffff, 16'hffff);
    send_command(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_command(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_command(16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    send_command(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_command(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);

    // random part, with bursts and one long hold-off at the result side
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (k == 200) begin
        hold_off_req = 1'b1;
        no_idle      = 1'b1;
      end
      send_command(pick_signed(), pick_signed(), pick_signed(), pick_period());
    end
    in_valid_i <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/hifr_pkg.sv
rtl/heading_integrate_frame_rotate.sv
tb/tb_heading_integrate_frame_rotate.sv
